// ===== hdl/sio_frm_pkg.sv =====
package sio_frm_pkg;

    localparam int MAX_FRAME = 1024;

    localparam int LEN_W   = 11;
    localparam int INDEX_W = 10;
    localparam int BYTE_W  = 8;

    localparam logic [BYTE_W-1:0] REPLY_ACK  = 8'h41;
    localparam logic [BYTE_W-1:0] REPLY_NACK = 8'h4e;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_LINE     = 2'd2
    } frame_status_t;

    typedef enum logic {
        REQ_BYTE = 1'b0,
        REQ_LINE = 1'b1
    } req_type_t;

    typedef struct packed {
        logic               req_type;
        logic [BYTE_W-1:0]  rx_byte;
        logic [LEN_W-1:0]   frame_length;
        logic               cmd_level;
        logic               expected_level;
    } sio_frm_req_t;

    typedef struct packed {
        logic                frame_done;
        logic [1:0]          frame_status;
        logic [BYTE_W-1:0]   reply_byte;
        logic                data_valid;
        logic [INDEX_W-1:0]  data_index;
        logic [BYTE_W-1:0]   data_byte;
    } sio_frm_result_t;

endpackage

// ===== hdl/sio_frm_if.sv =====
interface sio_frm_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  rx_byte;
    logic [10:0] frame_length;
    logic        cmd_level;
    logic        expected_level;

    modport source (
        output valid, req_type, rx_byte, frame_length, cmd_level, expected_level,
        input  ready
    );
    modport sink (
        input  valid, req_type, rx_byte, frame_length, cmd_level, expected_level,
        output ready
    );
endinterface

interface sio_frm_rsp_if;
    logic        valid;
    logic        ready;
    logic        frame_done;
    logic [1:0]  frame_status;
    logic [7:0]  reply_byte;
    logic        data_valid;
    logic [9:0]  data_index;
    logic [7:0]  data_byte;

    modport source (
        output valid, frame_done, frame_status, reply_byte, data_valid, data_index,
               data_byte,
        input  ready
    );
    modport sink (
        input  valid, frame_done, frame_status, reply_byte, data_valid, data_index,
               data_byte,
        output ready
    );
endinterface

// ===== hdl/sio_frame_receive_checker.sv =====
// a result is registered and appears in the cycle after its request is accepted
// throughput: one request per cycle unless the result side stalls; a single result register set by the
//   checksum add and length compare, and refilled in the cycle it is taken
// reset: byte count, running sum and latched length clear to zero, the
//   result register is empty
module sio_frame_receive_checker (
    input  logic          clk,
    input  logic          rst_n,
    sio_frm_req_if.sink   req,
    sio_frm_rsp_if.source rsp
);
    import sio_frm_pkg::*;

    sio_frm_req_t    item;
    sio_frm_result_t result;
    logic            take;

    assign item.req_type       = req.req_type;
    assign item.rx_byte        = req.rx_byte;
    assign item.frame_length   = req.frame_length;
    assign item.cmd_level      = req.cmd_level;
    assign item.expected_level = req.expected_level;

    sio_frm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (item),
        .result (result)
    );

    sio_frm_out u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .result (result),
        .take   (take)
    );

    // a result never both ends a frame and carries a data byte
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.frame_done && rsp.data_valid))
        else $error("frame end and data byte in one result");

    // reply and status stay zero unless the frame ends
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.frame_done) |-> (rsp.reply_byte == '0 && rsp.frame_status == '0))
        else $error("reply without frame end");

    // a line sample off its level gives an abort with nack next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && req.req_type == REQ_LINE && req.cmd_level != req.expected_level)
        |=> (rsp.valid && rsp.frame_done && rsp.frame_status == ST_LINE
             && rsp.reply_byte == REPLY_NACK))
        else $error("line abort not reported");

    // ok status always pairs with ack
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.frame_done) |->
        ((rsp.frame_status == ST_OK) == (rsp.reply_byte == REPLY_ACK)))
        else $error("status and reply disagree");

endmodule

// ===== hdl/sio_frm_core.sv =====
module sio_frm_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  sio_frm_pkg::sio_frm_req_t   item,
    output sio_frm_pkg::sio_frm_result_t result
);
    import sio_frm_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME);

    logic [LEN_W-1:0]  byte_count_reg, byte_count_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic [LEN_W-1:0]  length_cur;
    logic [BYTE_W:0]   sum_wide;

    // first byte of a frame sees the fresh length, capped
    always_comb
    begin
        if (byte_count_reg == '0)
        begin
            length_cur = (item.frame_length > MAX_LEN) ? MAX_LEN : item.frame_length;
        end
        else
        begin
            length_cur = length_reg;
        end
    end

    assign sum_wide = {1'b0, sum_reg} + {1'b0, item.rx_byte};

    always_comb
    begin
        byte_count_next = byte_count_reg;
        sum_next        = sum_reg;
        length_next     = length_reg;
        result          = '0;
        if (item.req_type == REQ_LINE)
        begin
            if (item.cmd_level != item.expected_level)
            begin
                result.frame_done   = 1'b1;
                result.frame_status = ST_LINE;
                result.reply_byte   = REPLY_NACK;
                byte_count_next     = '0;
                sum_next            = '0;
            end
        end
        else
        begin
            if (byte_count_reg == '0)
            begin
                length_next = length_cur;
            end
            if (byte_count_reg >= length_cur)
            begin
                result.frame_done = 1'b1;
                if (item.rx_byte == sum_reg)
                begin
                    result.frame_status = ST_OK;
                    result.reply_byte   = REPLY_ACK;
                end
                else
                begin
                    result.frame_status = ST_MISMATCH;
                    result.reply_byte   = REPLY_NACK;
                end
                byte_count_next = '0;
                sum_next        = '0;
            end
            else
            begin
                // end-around carry folds bit 8 back into bit 0
                sum_next          = sum_wide[BYTE_W-1:0] + BYTE_W'(sum_wide[BYTE_W]);
                result.data_valid = 1'b1;
                result.data_index = byte_count_reg[INDEX_W-1:0];
                result.data_byte  = item.rx_byte;
                byte_count_next   = byte_count_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            sum_reg        <= '0;
            length_reg     <= '0;
        end
        else if (take)
        begin
            byte_count_reg <= byte_count_next;
            sum_reg        <= sum_next;
            length_reg     <= length_next;
        end
    end

endmodule

// ===== hdl/sio_frm_out.sv =====
module sio_frm_out (
    input  logic                         clk,
    input  logic                         rst_n,
    sio_frm_req_if.sink                  req,
    sio_frm_rsp_if.source                rsp,
    input  sio_frm_pkg::sio_frm_result_t result,
    output logic                         take
);
    import sio_frm_pkg::*;

    logic            valid_reg;
    sio_frm_result_t result_reg;

    // a new request enters whenever the result slot is empty or empties this cycle
    assign req.ready = !valid_reg || rsp.ready;
    assign take      = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result;
        end
    end

    assign rsp.valid        = valid_reg;
    assign rsp.frame_done   = result_reg.frame_done;
    assign rsp.frame_status = result_reg.frame_status;
    assign rsp.reply_byte   = result_reg.reply_byte;
    assign rsp.data_valid   = result_reg.data_valid;
    assign rsp.data_index   = result_reg.data_index;
    assign rsp.data_byte    = result_reg.data_byte;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sio_frm_pkg::*;

    localparam int RAND_ITEMS  = 1200;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 250;

    typedef struct {
        sio_frm_req_t    rq;
        bit              typed;
        sio_frm_result_t rsp;
    } dir_row_t;

    logic clk;
    logic rst_n;

    sio_frm_req_if req_if ();
    sio_frm_rsp_if rsp_if ();

    sio_frame_receive_checker u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // frame tracking state of the predictor
    logic [LEN_W-1:0]  frm_cnt;
    logic [BYTE_W-1:0] frm_sum;
    logic [LEN_W-1:0]  frm_len;

    sio_frm_result_t frame_results_q[$];
    sio_frm_result_t drv_expect;
    dir_row_t        dir_tab[$];

    int  mismatches;
    int  rand_items;
    int  sink_hold;
    bit  src_steady;
    bit  sink_steady;

    initial begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic sio_frm_result_t frame_outcome(input sio_frm_req_t r);
        sio_frm_result_t res;
        logic [BYTE_W:0] s;
        res = '0;
        if (r.req_type == REQ_LINE) begin
            if (r.cmd_level != r.expected_level) begin
                res.frame_done   = 1'b1;
                res.frame_status = ST_LINE;
                res.reply_byte   = REPLY_NACK;
                frm_cnt = '0;
                frm_sum = '0;
            end
        end
        else begin
            if (frm_cnt == 0)
                frm_len = (r.frame_length > MAX_FRAME) ? LEN_W'(MAX_FRAME) : r.frame_length;
            if (frm_cnt >= frm_len) begin
                res.frame_done = 1'b1;
                if (r.rx_byte == frm_sum) begin
                    res.frame_status = ST_OK;
                    res.reply_byte   = REPLY_ACK;
                end
                else begin
                    res.frame_status = ST_MISMATCH;
                    res.reply_byte   = REPLY_NACK;
                end
                frm_cnt = '0;
                frm_sum = '0;
            end
            else begin
                // end-around carry: fold bit 8 back into bit 0
                s = {1'b0, frm_sum} + {1'b0, r.rx_byte};
                frm_sum = s[BYTE_W-1:0] + BYTE_W'(s[BYTE_W]);
                res.data_valid = 1'b1;
                res.data_index = frm_cnt[INDEX_W-1:0];
                res.data_byte  = r.rx_byte;
                frm_cnt = frm_cnt + LEN_W'(1);
            end
        end
        return res;
    endfunction

    function automatic sio_frm_req_t make_req(input req_type_t kind, input logic [7:0] b,
                                              input logic [10:0] len, input logic lvl,
                                              input logic want_lvl);
        sio_frm_req_t r;
        r.req_type       = kind;
        r.rx_byte        = b;
        r.frame_length   = len;
        r.cmd_level      = lvl;
        r.expected_level = want_lvl;
        return r;
    endfunction

    function automatic sio_frm_result_t make_rsp(input logic done, input frame_status_t st,
                                                 input logic [7:0] reply, input logic dv,
                                                 input logic [9:0] idx, input logic [7:0] b);
        sio_frm_result_t res;
        res.frame_done   = done;
        res.frame_status = st;
        res.reply_byte   = reply;
        res.data_valid   = dv;
        res.data_index   = idx;
        res.data_byte    = b;
        return res;
    endfunction

    task automatic send_req(input sio_frm_req_t r, input bit typed, input sio_frm_result_t fixed);
        sio_frm_result_t want;
        int gap;
        want = frame_outcome(r);
        if (typed)
            want = fixed;
        gap = src_steady ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 99) == 0)
            src_steady = !src_steady;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid          <= 1'b1;
        req_if.req_type       <= r.req_type;
        req_if.rx_byte        <= r.rx_byte;
        req_if.frame_length   <= r.frame_length;
        req_if.cmd_level      <= r.cmd_level;
        req_if.expected_level <= r.expected_level;
        drv_expect            <= want;
        do @(posedge clk); while (!req_if.ready);
    endtask

    // a line sample at the expected level changes nothing, so it is not counted
    task automatic send_rand(input sio_frm_req_t r);
        send_req(r, 1'b0, '0);
        if (!(r.req_type == REQ_LINE && r.cmd_level == r.expected_level))
            rand_items++;
    endtask

    task automatic send_line(input bit abort);
        logic lvl;
        lvl = 1'($urandom_range(0, 1));
        send_rand(make_req(REQ_LINE, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)),
                           lvl, abort ? !lvl : lvl));
    endtask

    task automatic run_frame(input logic [10:0] flen);
        bit first;
        bit is_ck;
        bit good_ck;
        logic [7:0] b;
        if (frm_cnt != 0)
            send_line(1'b1);
        good_ck = ($urandom_range(0, 3) != 0);
        first = 1'b1;
        forever begin
            is_ck = first ? (flen == 0) : (frm_cnt >= frm_len);
            b = (is_ck && good_ck) ? frm_sum : 8'($urandom_range(0, 255));
            send_rand(make_req(REQ_BYTE, b, first ? flen : 11'($urandom_range(0, 2047)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            first = 1'b0;
            if (is_ck)
                break;
            if ($urandom_range(0, 19) == 0)
                send_line(1'b0);
            // long frames always run to their checksum byte
            if (flen <= 11'd40 && $urandom_range(0, 59) == 0) begin
                send_line(1'b1);
                break;
            end
        end
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (frame_results_q.size() != 0);
    endtask

    task automatic cmp_field(input string fname, input logic [10:0] want, input logic [10:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin
        sio_frm_result_t got;
        sio_frm_result_t want;
        if (rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = '{rsp_if.frame_done, rsp_if.frame_status, rsp_if.reply_byte,
                        rsp_if.data_valid, rsp_if.data_index, rsp_if.data_byte};
                if (frame_results_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    mismatches++;
                end
                else begin
                    want = frame_results_q.pop_front();
                    cmp_field("frame_done", 11'(want.frame_done), 11'(got.frame_done));
                    cmp_field("frame_status", 11'(want.frame_status), 11'(got.frame_status));
                    cmp_field("reply_byte", 11'(want.reply_byte), 11'(got.reply_byte));
                    cmp_field("data_valid", 11'(want.data_valid), 11'(got.data_valid));
                    cmp_field("data_index", 11'(want.data_index), 11'(got.data_index));
                    cmp_field("data_byte", 11'(want.data_byte), 11'(got.data_byte));
                end
            end
            if (req_if.valid && req_if.ready)
                frame_results_q.push_back(drv_expect);
        end
    end

    // result side: random stalls, plus a long hold when the sender asks for one
    initial begin
        int gap;
        rsp_if.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (sink_hold > 0) begin
                gap = sink_hold;
                sink_hold = 0;
            end
            else begin
                gap = sink_steady ? 0 : $urandom_range(0, 10);
            end
            if ($urandom_range(0, 99) == 0)
                sink_steady = !sink_steady;
            if (gap > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!rsp_if.valid);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int next_hold;
        bit long_done;
        rst_n                 <= 1'b0;
        req_if.valid          <= 1'b0;
        req_if.req_type       <= REQ_BYTE;
        req_if.rx_byte        <= '0;
        req_if.frame_length   <= '0;
        req_if.cmd_level      <= 1'b0;
        req_if.expected_level <= 1'b0;
        drv_expect            <= '0;
        frm_cnt     = '0;
        frm_sum     = '0;
        frm_len     = '0;
        mismatches  = 0;
        rand_items  = 0;
        sink_hold   = 0;
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        next_hold   = 300;
        long_done   = 1'b0;

        dir_tab.push_back('{make_req(REQ_LINE, 8'h00, 11'd0, 1'b0, 1'b0), 1'b1,
                            make_rsp(1'b0, ST_OK, 8'h00, 1'b0, 10'd0, 8'h00)});
        dir_tab.push_back('{make_req(REQ_LINE, 8'hff, 11'd2047, 1'b1, 1'b1), 1'b1,
                            make_rsp(1'b0, ST_OK, 8'h00, 1'b0, 10'd0, 8'h00)});
        // abort while no frame is in progress
        dir_tab.push_back('{make_req(REQ_LINE, 8'h00, 11'd0, 1'b1, 1'b0), 1'b1,
                            make_rsp(1'b1, ST_LINE, REPLY_NACK, 1'b0, 10'd0, 8'h00)});
        // zero length: first byte is the checksum
        dir_tab.push_back('{make_req(REQ_BYTE, 8'h00, 11'd0, 1'b0, 1'b0), 1'b1,
                            make_rsp(1'b1, ST_OK, REPLY_ACK, 1'b0, 10'd0, 8'h00)});
        dir_tab.push_back('{make_req(REQ_BYTE, 8'hff, 11'd0, 1'b1, 1'b0), 1'b1,
                            make_rsp(1'b1, ST_MISMATCH, REPLY_NACK, 1'b0, 10'd0, 8'h00)});
        dir_tab.push_back('{make_req(REQ_BYTE, 8'hff, 11'd3, 1'b0, 1'b1), 1'b1,
                            make_rsp(1'b0, ST_OK, 8'h00, 1'b1, 10'd0, 8'hff)});
        // length on later bytes is ignored; sum wraps with end-around carry
        dir_tab.push_back('{make_req(REQ_BYTE, 8'hff, 11'd2047, 1'b1, 1'b1), 1'b0, '0});
        dir_tab.push_back('{make_req(REQ_BYTE, 8'h02, 11'd0, 1'b0, 1'b0), 1'b0, '0});
        dir_tab.push_back('{make_req(REQ_BYTE, 8'h02, 11'd1, 1'b0, 1'b0), 1'b0, '0});
        dir_tab.push_back('{make_req(REQ_BYTE, 8'h80, 11'd2, 1'b0, 1'b0), 1'b0, '0});
        dir_tab.push_back('{make_req(REQ_LINE, 8'h00, 11'd0, 1'b0, 1'b1), 1'b1,
                            make_rsp(1'b1, ST_LINE, REPLY_NACK, 1'b0, 10'd0, 8'h00)});
        dir_tab.push_back('{make_req(REQ_BYTE, 8'h55, 11'd1, 1'b0, 1'b0), 1'b0, '0});
        dir_tab.push_back('{make_req(REQ_BYTE, 8'haa, 11'd0, 1'b0, 1'b0), 1'b0, '0});
        dir_tab.push_back('{make_req(REQ_BYTE, 8'h01, 11'd1, 1'b0, 1'b0), 1'b0, '0});
        dir_tab.push_back('{make_req(REQ_BYTE, 8'h01, 11'd0, 1'b0, 1'b0), 1'b0, '0});
        // length above the maximum gets capped
        dir_tab.push_back('{make_req(REQ_BYTE, 8'h7f, 11'd1100, 1'b0, 1'b0), 1'b0, '0});
        dir_tab.push_back('{make_req(REQ_BYTE, 8'h00, 11'd5, 1'b0, 1'b0), 1'b0, '0});
        dir_tab.push_back('{make_req(REQ_LINE, 8'h00, 11'd0, 1'b1, 1'b1), 1'b1,
                            make_rsp(1'b0, ST_OK, 8'h00, 1'b0, 10'd0, 8'h00)});
        dir_tab.push_back('{make_req(REQ_LINE, 8'h00, 11'd0, 1'b1, 1'b0), 1'b1,
                            make_rsp(1'b1, ST_LINE, REPLY_NACK, 1'b0, 10'd0, 8'h00)});
        dir_tab.push_back('{make_req(REQ_BYTE, 8'h00, 11'd2047, 1'b1, 1'b0), 1'b0, '0});
        dir_tab.push_back('{make_req(REQ_LINE, 8'hff, 11'd0, 1'b0, 1'b1), 1'b1,
                            make_rsp(1'b1, ST_LINE, REPLY_NACK, 1'b0, 10'd0, 8'h00)});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_req(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].rsp);

        while (rand_items < RAND_ITEMS) begin
            if (rand_items >= next_hold) begin
                sink_hold = HOLD_CYCLES;
                next_hold += 500;
            end
            if (!long_done && rand_items >= RAND_ITEMS / 8) begin
                // one full-size frame
                run_frame(11'($urandom_range(1024, 2047)));
                long_done = 1'b1;
                drain();
            end
            else if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 4))
                    send_rand(make_req(req_type_t'($urandom_range(0, 1)),
                                       8'($urandom_range(0, 255)),
                                       11'($urandom_range(0, 2047)),
                                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            end
            else if ($urandom_range(0, 9) == 0) begin
                run_frame(11'($urandom_range(9, 40)));
            end
            else begin
                run_frame(11'($urandom_range(0, 8)));
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && frame_results_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sio_frm_pkg.sv
hdl/sio_frm_if.sv
hdl/sio_frm_core.sv
hdl/sio_frm_out.sv
hdl/sio_frame_receive_checker.sv
verif/tb_top.sv
